[hw/rtl/ttyld_pkg.sv]
// Shared types, character codes and control encodings of the terminal line discipline.
// Used by ttyld_seq, ttyld_dp and tty_line_discipline; depends on nothing else.
package ttyld_pkg;

    localparam int LINE_DEPTH_DEF = 16;

    // Character codes
    localparam logic [7:0] CH_INTR  = 8'h03;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_KILL  = 8'h15;
    localparam logic [7:0] CH_SUSP  = 8'h1A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANON   = 4'd0,
        CFG_ECHO    = 4'd1,
        CFG_ECHOE   = 4'd2,
        CFG_ECHONL  = 4'd3,
        CFG_ECHOCTL = 4'd4,
        CFG_ISIG    = 4'd5,
        CFG_ECHOK   = 4'd6,
        CFG_ECHOKE  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic canonical_mode;
        logic echo_enable;
        logic echo_erase;
        logic echo_newline;
        logic echo_control;
        logic signal_enable;
        logic kill_newline;
        logic kill_erase;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        canonical_mode: 1'b1, echo_enable: 1'b1, echo_erase: 1'b1, echo_newline: 1'b0,
        echo_control: 1'b1, signal_enable: 1'b1, kill_newline: 1'b0, kill_erase: 1'b1
    };

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_TERM = 2'd1,
        SIG_STOP = 2'd2
    } t_sig;

    // Result beat, lowest bit first: echo_valid, echo_byte, data_valid,
    // data_byte, key_taken, signal_request, zero pad.
    typedef struct packed {
        logic [2:0] pad;
        logic [1:0] signal_request;
        logic       key_taken;
        logic [7:0] data_byte;
        logic       data_valid;
        logic [7:0] echo_byte;
        logic       echo_valid;
    } t_result;

    // Datapath operation of one microstep
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RD_NEWEST,
        OP_RD_OLDEST,
        OP_POP,
        OP_PUSH,
        OP_DEC
    } t_dp_op;

    // Result produced by one microstep: an echo byte or the final status beat
    typedef enum logic [3:0] {
        EM_NONE,
        EM_SP,
        EM_BS,
        EM_NL,
        EM_CARET,
        EM_QMARK,
        EM_KEY,
        EM_KEYCTL,
        EM_F_IDLE,
        EM_F_DRAIN,
        EM_F_DATA,
        EM_F_TAKEN,
        EM_F_SIGC,
        EM_F_SIGZ
    } t_emit;

    typedef struct packed {
        t_dp_op op;
        t_emit  emit;
        logic   advance;
        logic   load_key;
    } t_dp_ctrl;

    typedef struct packed {
        logic       slot_free;
        logic       cnt_zero;
        logic       key_valid;
        logic [7:0] key_code;
        logic [7:0] rd_byte;
    } t_dp_stat;

endpackage

[hw/rtl/ttyld_seq.sv]
// Microcode sequencer: program ROM, step counter, condition select and key dispatch.
// Depends on ttyld_pkg; drives ttyld_dp through t_dp_ctrl.
module ttyld_seq import ttyld_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_dp_stat i_stat,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output t_dp_ctrl o_ctrl
);

    localparam int UPC_W = 6;
    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [2:0] {
        SQ_NEXT,
        SQ_WAIT,
        SQ_DISP,
        SQ_JMP,
        SQ_GOTO
    } t_seq_op;

    typedef enum logic [2:0] {
        C_NO_ECHO,
        C_NO_ECHO_NL,
        C_RAW,
        C_EMPTY,
        C_NO_ECHOKE,
        C_NO_ECHOK,
        C_NO_ECHOE,
        C_NO_ECHOCTL
    } t_cond;

    typedef struct packed {
        t_seq_op seq;
        t_cond   cond;
        t_upc    target;
        t_dp_op  op;
        t_emit   emit;
    } t_uword;

    localparam t_upc L_IDLE   = 6'd0;
    localparam t_upc L_DISP   = 6'd1;
    localparam t_upc L_DRAIN  = 6'd2;
    localparam t_upc L_NOKEY  = 6'd4;
    localparam t_upc L_TAB    = 6'd5;
    localparam t_upc L_FDATA  = 6'd10;
    localparam t_upc L_FTAKEN = 6'd11;
    localparam t_upc L_FSIGC  = 6'd12;
    localparam t_upc L_FSIGZ  = 6'd13;
    localparam t_upc L_NL     = 6'd14;
    localparam t_upc L_PUSHQ  = 6'd16;
    localparam t_upc L_KILL   = 6'd18;
    localparam t_upc L_KEND   = 6'd23;
    localparam t_upc L_ERASE  = 6'd25;
    localparam t_upc L_ERCTL  = 6'd30;
    localparam t_upc L_RAWER  = 6'd33;
    localparam t_upc L_CTRL   = 6'd35;
    localparam t_upc L_PRINT  = 6'd38;

    function automatic t_uword uw(t_seq_op s, t_cond c, t_upc t, t_dp_op o, t_emit e);
        return '{seq: s, cond: c, target: t, op: o, emit: e};
    endfunction

    function automatic t_uword rom(t_upc a);
        case (a)
            // wait for a read attempt, fetch the newest entry
            6'd0:  return uw(SQ_WAIT, C_NO_ECHO, L_DISP, OP_RD_NEWEST, EM_NONE);
            6'd1:  return uw(SQ_DISP, C_NO_ECHO, L_IDLE, OP_NONE, EM_NONE);
            // hand out the oldest entry
            6'd2:  return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_RD_OLDEST, EM_NONE);
            6'd3:  return uw(SQ_GOTO, C_NO_ECHO, L_IDLE, OP_POP, EM_F_DRAIN);
            6'd4:  return uw(SQ_GOTO, C_NO_ECHO, L_IDLE, OP_NONE, EM_F_IDLE);
            // tab
            6'd5:  return uw(SQ_JMP, C_NO_ECHO, L_FDATA, OP_NONE, EM_NONE);
            6'd6:  return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_SP);
            6'd7:  return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_SP);
            6'd8:  return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_SP);
            6'd9:  return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_SP);
            // final status beats
            6'd10: return uw(SQ_GOTO, C_NO_ECHO, L_IDLE, OP_NONE, EM_F_DATA);
            6'd11: return uw(SQ_GOTO, C_NO_ECHO, L_IDLE, OP_NONE, EM_F_TAKEN);
            6'd12: return uw(SQ_GOTO, C_NO_ECHO, L_IDLE, OP_NONE, EM_F_SIGC);
            6'd13: return uw(SQ_GOTO, C_NO_ECHO, L_IDLE, OP_NONE, EM_F_SIGZ);
            // newline
            6'd14: return uw(SQ_JMP, C_NO_ECHO_NL, L_PUSHQ, OP_NONE, EM_NONE);
            6'd15: return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_NL);
            // buffer in canonical mode, return directly in raw mode
            6'd16: return uw(SQ_JMP, C_RAW, L_FDATA, OP_NONE, EM_NONE);
            6'd17: return uw(SQ_GOTO, C_NO_ECHO, L_IDLE, OP_PUSH, EM_F_TAKEN);
            // line kill loop
            6'd18: return uw(SQ_JMP, C_EMPTY, L_KEND, OP_NONE, EM_NONE);
            6'd19: return uw(SQ_JMP, C_NO_ECHOKE, L_KILL, OP_DEC, EM_NONE);
            6'd20: return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_BS);
            6'd21: return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_SP);
            6'd22: return uw(SQ_GOTO, C_NO_ECHO, L_KILL, OP_NONE, EM_BS);
            6'd23: return uw(SQ_JMP, C_NO_ECHOK, L_FTAKEN, OP_NONE, EM_NONE);
            6'd24: return uw(SQ_GOTO, C_NO_ECHO, L_FTAKEN, OP_NONE, EM_NL);
            // erase one entry
            6'd25: return uw(SQ_JMP, C_EMPTY, L_FTAKEN, OP_NONE, EM_NONE);
            6'd26: return uw(SQ_JMP, C_NO_ECHOE, L_ERCTL, OP_DEC, EM_NONE);
            6'd27: return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_BS);
            6'd28: return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_SP);
            6'd29: return uw(SQ_GOTO, C_NO_ECHO, L_FTAKEN, OP_NONE, EM_BS);
            6'd30: return uw(SQ_JMP, C_NO_ECHO, L_FTAKEN, OP_NONE, EM_NONE);
            6'd31: return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_CARET);
            6'd32: return uw(SQ_GOTO, C_NO_ECHO, L_FTAKEN, OP_NONE, EM_QMARK);
            // erase or kill byte in raw mode
            6'd33: return uw(SQ_JMP, C_NO_ECHO, L_FDATA, OP_NONE, EM_NONE);
            6'd34: return uw(SQ_GOTO, C_NO_ECHO, L_FDATA, OP_NONE, EM_KEY);
            // other control characters
            6'd35: return uw(SQ_JMP, C_NO_ECHOCTL, L_PUSHQ, OP_NONE, EM_NONE);
            6'd36: return uw(SQ_NEXT, C_NO_ECHO, L_IDLE, OP_NONE, EM_CARET);
            6'd37: return uw(SQ_GOTO, C_NO_ECHO, L_PUSHQ, OP_NONE, EM_KEYCTL);
            // printable characters
            6'd38: return uw(SQ_JMP, C_NO_ECHO, L_PUSHQ, OP_NONE, EM_NONE);
            6'd39: return uw(SQ_GOTO, C_NO_ECHO, L_PUSHQ, OP_NONE, EM_KEY);
            default: return uw(SQ_GOTO, C_NO_ECHO, L_IDLE, OP_NONE, EM_NONE);
        endcase
    endfunction

    function automatic t_upc dispatch(t_cfg cfg, t_dp_stat st);
        if (!st.cnt_zero && (!cfg.canonical_mode || st.rd_byte == CH_NL)) return L_DRAIN;
        if (!st.key_valid)                                             return L_NOKEY;
        if (st.key_code == CH_TAB)                                     return L_TAB;
        if (st.key_code == CH_NL)                                      return L_NL;
        if (st.key_code inside {CH_KILL, CH_BS, CH_DEL}) begin
            if (!cfg.canonical_mode)                                   return L_RAWER;
            if (st.key_code == CH_KILL)                                return L_KILL;
            return L_ERASE;
        end
        if (st.key_code < CH_CTRL_LIMIT) begin
            if (cfg.signal_enable && st.key_code == CH_INTR)           return L_FSIGC;
            if (cfg.signal_enable && st.key_code == CH_SUSP)           return L_FSIGZ;
            return L_CTRL;
        end
        return L_PRINT;
    endfunction

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w;
    logic   cond_hit;
    logic   adv;
    logic   is_final;

    assign w = rom(r_upc);

    always_comb begin
        case (w.cond)
            C_NO_ECHO:    cond_hit = !i_cfg.echo_enable;
            C_NO_ECHO_NL: cond_hit = !(i_cfg.echo_enable ||
                                       (i_cfg.canonical_mode && i_cfg.echo_newline));
            C_RAW:        cond_hit = !i_cfg.canonical_mode;
            C_EMPTY:      cond_hit = i_stat.cnt_zero;
            C_NO_ECHOKE:  cond_hit = !i_cfg.kill_erase;
            C_NO_ECHOK:   cond_hit = !i_cfg.kill_newline;
            C_NO_ECHOE:   cond_hit = !i_cfg.echo_erase;
            C_NO_ECHOCTL: cond_hit = !(i_cfg.echo_enable && i_cfg.echo_control);
            default:      cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        // hold the wait step while no input beat is offered, and any step while its result cannot be placed
        if (w.seq == SQ_WAIT)      adv = i_in_valid;
        else if (w.emit != EM_NONE) adv = i_stat.slot_free;
        else                       adv = 1'b1;

        case (w.seq)
            SQ_NEXT: n_upc = r_upc + t_upc'(1);
            SQ_WAIT: n_upc = w.target;
            SQ_DISP: n_upc = dispatch(i_cfg, i_stat);
            SQ_JMP:  n_upc = cond_hit ? w.target : r_upc + t_upc'(1);
            SQ_GOTO: n_upc = w.target;
            default: n_upc = L_IDLE;
        endcase
        if (!adv) n_upc = r_upc;
    end

    assign is_final   = (w.emit == EM_F_IDLE) || (w.emit == EM_F_DRAIN) ||
                        (w.emit == EM_F_DATA) || (w.emit == EM_F_TAKEN) ||
                        (w.emit == EM_F_SIGC) || (w.emit == EM_F_SIGZ);
    assign o_in_ready = (w.seq == SQ_WAIT);
    assign o_ctrl     = '{op: w.op, emit: w.emit, advance: adv,
                          load_key: (w.seq == SQ_WAIT) && adv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= L_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Return to the idle step only right after a final status beat was loaded.
    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_upc == L_IDLE && $past(r_upc) != L_IDLE) |->
            $past(adv && is_final))
        else $error("sequencer returned to idle without a final beat");

    // A new key is latched only from the idle step, and dispatch follows.
    a_dispatch_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load_key |=> r_upc == L_DISP)
        else $error("dispatch did not follow key load");

endmodule

[hw/rtl/ttyld_dp.sv]
// Datapath: line store memory, oldest pointer, entry count, key latch and result register.
// Depends on ttyld_pkg; steered by ttyld_seq through t_dp_ctrl.
module ttyld_dp import ttyld_pkg::*; #(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_ctrl i_ctrl,
    input  logic     i_key_valid,
    input  logic [7:0] i_key_code,
    input  logic     i_m_ready,
    output t_dp_stat o_stat,
    output t_result  o_out,
    output logic     o_out_valid,
    output logic     o_out_last
);

    localparam int PW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(LINE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);

    logic [7:0]    r_mem [LINE_DEPTH];
    logic [7:0]    r_rd;
    logic [7:0]    r_key;
    logic          r_keyv;
    logic [PW-1:0] r_old;
    logic [CW-1:0] r_cnt;
    logic          r_ovld;
    t_result       r_out;
    logic          r_olast;

    logic [SW-1:0] tail_sum, newest_sum, old_inc;
    logic [PW-1:0] tail_idx, newest_idx, old_next;
    logic          full;
    logic          emit_go;
    t_result       n_out;
    logic          n_last;

    // Ring arithmetic: every sum stays below twice the depth.
    always_comb begin
        tail_sum   = SW'(r_old) + SW'(r_cnt);
        newest_sum = (r_cnt == '0) ? SW'(r_old) : SW'(r_old) + SW'(r_cnt) - SW'(1);
        old_inc    = SW'(r_old) + SW'(1);
        tail_idx   = (tail_sum >= DEPTH_S) ? PW'(tail_sum - DEPTH_S) : tail_sum[PW-1:0];
        newest_idx = (newest_sum >= DEPTH_S) ? PW'(newest_sum - DEPTH_S)
                                             : newest_sum[PW-1:0];
        old_next   = (old_inc == DEPTH_S) ? '0 : old_inc[PW-1:0];
    end

    assign full    = (r_cnt == DEPTH_C);
    assign emit_go = i_ctrl.advance && (i_ctrl.emit != EM_NONE);

    always_comb begin
        n_out  = '0;
        n_last = 1'b0;
        case (i_ctrl.emit)
            EM_NONE:    ;
            EM_SP:      begin n_out.echo_valid = 1'b1; n_out.echo_byte = CH_SP;    end
            EM_BS:      begin n_out.echo_valid = 1'b1; n_out.echo_byte = CH_BS;    end
            EM_NL:      begin n_out.echo_valid = 1'b1; n_out.echo_byte = CH_NL;    end
            EM_CARET:   begin n_out.echo_valid = 1'b1; n_out.echo_byte = CH_CARET; end
            EM_QMARK:   begin n_out.echo_valid = 1'b1; n_out.echo_byte = CH_QMARK; end
            EM_KEY:     begin n_out.echo_valid = 1'b1; n_out.echo_byte = r_key;    end
            EM_KEYCTL:  begin n_out.echo_valid = 1'b1; n_out.echo_byte = r_key + CH_AT; end
            EM_F_IDLE:  n_last = 1'b1;
            EM_F_DRAIN: begin
                n_out.data_valid = 1'b1;
                n_out.data_byte  = r_rd;
                n_last           = 1'b1;
            end
            EM_F_DATA:  begin
                n_out.data_valid = 1'b1;
                n_out.data_byte  = r_key;
                n_out.key_taken  = 1'b1;
                n_last           = 1'b1;
            end
            EM_F_TAKEN: begin n_out.key_taken = 1'b1; n_last = 1'b1; end
            EM_F_SIGC:  begin
                n_out.key_taken      = 1'b1;
                n_out.signal_request = SIG_TERM;
                n_last               = 1'b1;
            end
            EM_F_SIGZ:  begin
                n_out.key_taken      = 1'b1;
                n_out.signal_request = SIG_STOP;
                n_last               = 1'b1;
            end
            default:    ;
        endcase
    end

    // Line store and its registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance && i_ctrl.op == OP_PUSH && !full) begin
            r_mem[tail_idx] <= r_key;
        end
        if (i_ctrl.advance && i_ctrl.op == OP_RD_NEWEST) begin
            r_rd <= r_mem[newest_idx];
        end else if (i_ctrl.advance && i_ctrl.op == OP_RD_OLDEST) begin
            r_rd <= r_mem[r_old];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_key) begin
            r_key  <= i_key_code;
            r_keyv <= i_key_valid;
        end
        if (emit_go) begin
            r_out   <= n_out;
            r_olast <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old  <= '0;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_ctrl.advance) begin
                case (i_ctrl.op)
                    OP_PUSH: if (!full) r_cnt <= r_cnt + CW'(1);
                    OP_POP:  begin
                        r_old <= old_next;
                        r_cnt <= r_cnt - CW'(1);
                    end
                    OP_DEC:  r_cnt <= r_cnt - CW'(1);
                    default: ;
                endcase
            end
            if (emit_go)        r_ovld <= 1'b1;
            else if (i_m_ready) r_ovld <= 1'b0;
        end
    end

    assign o_stat = '{slot_free: !r_ovld || i_m_ready, cnt_zero: (r_cnt == '0),
                      key_valid: r_keyv, key_code: r_key, rd_byte: r_rd};
    assign o_out       = r_out;
    assign o_out_valid = r_ovld;
    assign o_out_last  = r_olast;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.advance && (i_ctrl.op == OP_POP || i_ctrl.op == OP_DEC) |-> r_cnt != '0)
        else $error("line store underflow");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |-> !r_ovld || i_m_ready)
        else $error("result register overwritten while pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.advance && i_ctrl.op == OP_PUSH |=> r_cnt <= DEPTH_C && r_cnt != '0)
        else $error("entry count out of range after push");

endmodule

[hw/rtl/tty_line_discipline.sv]
// Terminal line discipline, top level: configuration registers, sequencer and datapath.
// Depends on ttyld_pkg, ttyld_seq and ttyld_dp.
//
// Usage:
//   s_axis  - one beat per read attempt: key_valid and key_code.
//   m_axis  - result beats: zero or more echo beats, then one status beat
//             with tlast high carrying data, key_taken and signal_request.
//   i_cfg_* - register writes (index 0..7, bit 0 of the data kept); always
//             ready, write only while the block is idle.
// Program flow: an input beat is taken only at the idle step of the
//   control program. Per item the program accepts the beat, dispatches
//   on the key class, then walks the program steps; each result beat is
//   one step. A new beat is not taken until the item's final status beat
//   has been loaded and the program is back at the idle step.
// Reset: the line store empties (count and oldest pointer cleared), the
//   registers take their defaults, the sequencer returns to idle.
// Stall: when m_axis_tready is low the pending result holds and the
//   program step that wants to emit waits; an input beat may still be
//   accepted while the last status beat of an item is waiting.
module tty_line_discipline import ttyld_pkg::*; #(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // input beats
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // [0] key_valid, [8:1] key_code, [15:9] zero
    // result beats
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] echo_valid, [8:1] echo_byte, [9] data_valid, [17:10] data_byte,
    // [18] key_taken, [20:19] signal_request, [23:21] zero
    output logic [23:0]          m_axis_tdata,
    output logic                 m_axis_tlast
);

    t_cfg     r_cfg;
    t_dp_ctrl ctrl;
    t_dp_stat stat;
    t_result  out_beat;

    // Configuration registers: take bit 0, ignore indexes past the list
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CANON:   r_cfg.canonical_mode <= i_cfg_data[0];
                CFG_ECHO:    r_cfg.echo_enable    <= i_cfg_data[0];
                CFG_ECHOE:   r_cfg.echo_erase     <= i_cfg_data[0];
                CFG_ECHONL:  r_cfg.echo_newline   <= i_cfg_data[0];
                CFG_ECHOCTL: r_cfg.echo_control   <= i_cfg_data[0];
                CFG_ISIG:    r_cfg.signal_enable  <= i_cfg_data[0];
                CFG_ECHOK:   r_cfg.kill_newline   <= i_cfg_data[0];
                CFG_ECHOKE:  r_cfg.kill_erase     <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Control program: owns the input handshake and the step order
    ttyld_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_stat     (stat),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (ctrl)
    );

    // Line store, counters and the result register
    ttyld_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_key_valid (s_axis_tdata[0]),
        .i_key_code  (s_axis_tdata[8:1]),
        .i_m_ready   (m_axis_tready),
        .o_stat      (stat),
        .o_out       (out_beat),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_beat;

endmodule
